// ----- hdl/hbd_pkg.sv -----
package hbd_pkg;

  localparam int MaxSymbolsDef = 256;
  localparam int ActW          = 2;
  localparam int SymW          = 8;

  typedef enum logic [ActW-1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_LOAD   = 2'd1,
    ACT_DECODE = 2'd2,
    ACT_NOP    = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } st_e;

endpackage

// ----- hdl/hbd_if.sv -----
interface hbd_in_if import hbd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ActW-1:0] action;
  logic            node_is_internal;
  logic [SymW-1:0] leaf_symbol;
  logic            code_bit;
  logic            final_bit;

  modport source (
    output valid, action, node_is_internal, leaf_symbol, code_bit, final_bit,
    input  ready
  );
  modport sink (
    input  valid, action, node_is_internal, leaf_symbol, code_bit, final_bit,
    output ready
  );
endinterface

interface hbd_out_if import hbd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [SymW-1:0] symbol;
  logic            incomplete;
  logic            last;

  modport source (
    output valid, symbol, incomplete, last,
    input  ready
  );
  modport sink (
    input  valid, symbol, incomplete, last,
    output ready
  );
endinterface

// ----- hdl/hbd_ram.sv -----
module hbd_ram import hbd_pkg::*; #(
  parameter int  Width = SymW,
  parameter int  Depth = MaxSymbolsDef,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // read-first: a read and a write of one entry at the same edge return the old data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if ({1'b0, raddr_i} < (AddrW+1)'(Depth)) begin
        rdata_q <= mem[raddr_i];
      end else begin
        rdata_q <= '0;
      end
    end
    if (we_i && ({1'b0, waddr_i} < (AddrW+1)'(Depth))) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/huffman_tree_bit_decoder_top.sv -----
// Huffman tree-walk decoder.
// in_i carries one item per handshake: action clear, load or decode (the
// fourth code does nothing). Loads build the code tree in pre-order; decode
// items feed one code bit each. out_o returns one item with symbol,
// incomplete and last for each decode bit that reaches a leaf or that ends
// the stream mid-code; clear, load and non-leaf bits return nothing.
// Every accepted item occupies the block for the accept cycle and the
// execute cycle, in which a decode bit gets the node table read issued
// at accept (registered synchronous read) and a load writes its parent link
// (the table has a single write port). No new item is taken until the
// execute cycle ends; the result of a decode bit is registered there and
// appears on out_o in the cycle after the execute cycle.
// The output register lets the next item be accepted while a result waits.
// If out_o stalls with a result still held and another result is due, the
// execute cycle holds and in_i.ready stays low until the slot frees.
// Reset (rst_ni low, asynchronous) empties the tree counters, the stack
// pointer and the walk position; the table and stack contents are kept
// and are defined only once loaded.
module huffman_tree_bit_decoder_top import hbd_pkg::*; #(
  parameter int MaxSymbols = MaxSymbolsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  hbd_in_if.sink    in_i,
  hbd_out_if.source out_o
);

  localparam int NodeCap = 2 * MaxSymbols - 1;
  localparam int IdxW    = $clog2(NodeCap);
  localparam int CntW    = $clog2(NodeCap + 1);
  localparam int SpW     = $clog2(MaxSymbols + 1);
  localparam int StkW    = $clog2(MaxSymbols);
  localparam int EntW    = 1 + SymW + 2 * IdxW;
  localparam int LeafBit = EntW - 1;

  typedef struct packed {
    logic            dec;
    logic            link;
    logic            left;
    logic [IdxW-1:0] idx;
    logic            leaf;
    logic [SymW-1:0] sym;
    logic            fin;
    logic [IdxW-1:0] next;
  } exec_t;

  st_e             state_q, state_d;
  exec_t           exec_q, exec_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [SpW-1:0]  sp_q, sp_d;
  logic            prev_int_q, prev_int_d;
  logic [IdxW-1:0] walk_q, walk_d;
  logic [EntW-1:0] cur_q, cur_d;
  logic [EntW-1:0] root_q, root_d;

  logic            out_valid_q, out_valid_d;
  logic [SymW-1:0] out_sym_q, out_sym_d;
  logic            out_inc_q, out_inc_d;
  logic            out_last_q, out_last_d;

  logic            in_fire;
  logic            is_clear, is_load, is_dec;
  logic            pop, ld_ok;
  logic [IdxW-1:0] idx;
  logic [EntW-1:0] new_entry;

  logic            node_we;
  logic [IdxW-1:0] node_waddr;
  logic [EntW-1:0] node_wdata;
  logic [IdxW-1:0] node_raddr;
  logic [EntW-1:0] node_rdata;

  logic            stk_we, stk_re;
  logic [StkW-1:0] stk_waddr, stk_raddr;
  logic [IdxW-1:0] stk_rdata;

  logic            rd_leaf, has_res, stall, advance, produce;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    is_clear = 1'b0;
    is_load  = 1'b0;
    is_dec   = 1'b0;
    case (in_i.action)
      ACT_CLEAR:  is_clear = in_fire;
      ACT_LOAD:   is_load  = in_fire;
      ACT_DECODE: is_dec   = in_fire;
      ACT_NOP:    ;
      default:    ;
    endcase
  end

  // load admission: room left, a parent waiting, stack not full for an internal node
  assign idx       = cnt_q[IdxW-1:0];
  assign pop       = (cnt_q != '0) && !prev_int_q;
  assign ld_ok     = is_load && (cnt_q < CntW'(NodeCap)) && !(pop && (sp_q == '0)) &&
                     !(in_i.node_is_internal && (sp_q == SpW'(MaxSymbols)));
  assign new_entry = in_i.node_is_internal ? '0 :
                     {1'b1, in_i.leaf_symbol, {(2*IdxW){1'b0}}};

  // execute cycle of a decode bit
  assign rd_leaf = node_rdata[LeafBit];
  assign has_res = exec_q.dec && (exec_q.leaf || rd_leaf || exec_q.fin);
  assign stall   = has_res && out_valid_q && !out_o.ready;
  assign advance = (state_q == ST_EXEC) && !stall;
  assign produce = advance && has_res;

  // single write port: new node at accept, parent link in the execute cycle
  always_comb begin
    node_we    = 1'b0;
    node_waddr = idx;
    node_wdata = new_entry;
    if (ld_ok) begin
      node_we = 1'b1;
    end else if ((state_q == ST_EXEC) && exec_q.link) begin
      node_we = 1'b1;
      if (exec_q.left) begin
        node_waddr = exec_q.idx - IdxW'(1);
        node_wdata = {1'b0, {SymW{1'b0}}, exec_q.idx, {IdxW{1'b0}}};
      end else begin
        // a popped parent already has its left child right after it
        node_waddr = stk_rdata;
        node_wdata = {1'b0, {SymW{1'b0}}, stk_rdata + IdxW'(1), exec_q.idx};
      end
    end
  end

  assign node_raddr = in_i.code_bit ? cur_q[IdxW-1:0] : cur_q[2*IdxW-1:IdxW];

  assign stk_we    = ld_ok && in_i.node_is_internal;
  assign stk_waddr = pop ? StkW'(sp_q - SpW'(1)) : StkW'(sp_q);
  assign stk_re    = ld_ok && pop;
  assign stk_raddr = StkW'(sp_q - SpW'(1));

  always_comb begin
    state_d     = state_q;
    exec_d      = exec_q;
    cnt_d       = cnt_q;
    sp_d        = sp_q;
    prev_int_d  = prev_int_q;
    walk_d      = walk_q;
    cur_d       = cur_q;
    root_d      = root_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_sym_d   = out_sym_q;
    out_inc_d   = out_inc_q;
    out_last_d  = out_last_q;

    // keep the mirrors of the root and the walk node in step with the table
    if (node_we) begin
      if (node_waddr == walk_q) cur_d = node_wdata;
      if (node_waddr == '0) root_d = node_wdata;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d     = ST_EXEC;
          exec_d.dec  = is_dec;
          exec_d.link = ld_ok && (cnt_q != '0);
          exec_d.left = prev_int_q;
          exec_d.idx  = idx;
          exec_d.leaf = cur_q[LeafBit];
          exec_d.sym  = cur_q[LeafBit-1 -: SymW];
          exec_d.fin  = in_i.final_bit;
          exec_d.next = node_raddr;
        end
        if (is_clear) begin
          cnt_d      = '0;
          sp_d       = '0;
          prev_int_d = 1'b0;
          walk_d     = '0;
          cur_d      = root_q;
        end
        if (ld_ok) begin
          cnt_d      = cnt_q + CntW'(1);
          sp_d       = sp_q - SpW'(pop) + SpW'(in_i.node_is_internal);
          prev_int_d = in_i.node_is_internal;
        end
      end
      ST_EXEC: begin
        if (advance) begin
          state_d = ST_IDLE;
          if (exec_q.dec) begin
            if (has_res) begin
              walk_d = '0;
              cur_d  = root_q;
            end else begin
              walk_d = exec_q.next;
              cur_d  = node_rdata;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (produce) begin
      out_valid_d = 1'b1;
      out_last_d  = exec_q.fin;
      out_inc_d   = 1'b0;
      if (exec_q.leaf) begin
        out_sym_d = exec_q.sym;
      end else if (rd_leaf) begin
        out_sym_d = node_rdata[LeafBit-1 -: SymW];
      end else begin
        out_sym_d = '0;
        out_inc_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      sp_q        <= '0;
      prev_int_q  <= 1'b0;
      walk_q      <= '0;
      cur_q       <= '0;
      root_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sp_q        <= sp_d;
      prev_int_q  <= prev_int_d;
      walk_q      <= walk_d;
      cur_q       <= cur_d;
      root_q      <= root_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    exec_q     <= exec_d;
    out_sym_q  <= out_sym_d;
    out_inc_q  <= out_inc_d;
    out_last_q <= out_last_d;
  end

  hbd_ram #(
    .Width (EntW),
    .Depth (NodeCap)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .re_i    (is_dec),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  hbd_ram #(
    .Width (IdxW),
    .Depth (MaxSymbols)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (idx),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign out_o.valid      = out_valid_q;
  assign out_o.symbol     = out_sym_q;
  assign out_o.incomplete = out_inc_q;
  assign out_o.last       = out_last_q;

`ifndef SYNTH
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SpW'(MaxSymbols))
    else $error("parent stack pointer beyond capacity");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(NodeCap))
    else $error("node count beyond capacity");

  a_res_from_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    produce |-> (state_q == ST_EXEC) && exec_q.dec && !exec_q.link)
    else $error("result produced outside a decode execute cycle");

  a_exec_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) && !exec_q.dec |=> state_q == ST_IDLE)
    else $error("non-decode item held the execute cycle");
`endif

endmodule

// ----- tb/tb_huffman_tree_bit_decoder_top.sv -----
module tb_huffman_tree_bit_decoder_top;
  import hbd_pkg::*;

  localparam int MaxSym    = 32;
  localparam int NodeCap   = 2 * MaxSym - 1;
  localparam int TblDepth  = 511;
  localparam int RandItems = 850;
  localparam int HoldCyc   = 100;

  typedef struct packed {
    act_e            act;
    logic            internal;
    logic [SymW-1:0] sym;
    logic            cbit;
    logic            fin;
    logic            drain;
    logic            hold;
  } stim_t;

  typedef struct packed {
    logic [SymW-1:0] sym;
    logic            incomplete;
    logic            last;
  } sym_res_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  hbd_in_if  in_if ();
  hbd_out_if out_if ();

  huffman_tree_bit_decoder_top #(
    .MaxSymbols(MaxSym)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #6 clk_i = ~clk_i;

  // predicted tree state
  logic [26:0] code_tree [TblDepth];
  logic [8:0]  open_parents [256];
  int          open_sp;
  logic [9:0]  node_cnt;
  logic        prev_int;
  logic [8:0]  walk_pos;

  stim_t    stim_q [$];
  sym_res_t sym_exp_q [$];

  // code paths of the leaves of the last generated tree
  logic [63:0] leaf_bits [$];
  int          leaf_len [$];

  stim_t cur_stim;
  bit    src_busy;
  int    src_gap;
  int    hold_tick = 0;
  int    hold_seen = 0;
  int    hold_cnt  = 0;
  int    snk_gap   = 0;
  bit    snk_rdy;
  int    err_cnt   = 0;
  int    rnd_cnt;
  int    seg;
  int    pick;
  int    nleaf;

  function automatic logic [26:0] node_at(logic [8:0] i);
    return (i < TblDepth) ? code_tree[i] : 27'd0;
  endfunction

  function automatic bit idling_allowed();
    return stim_q.size() > 120;
  endfunction

  task automatic walk_tree_item(input stim_t it);
    logic [26:0] ent;
    logic [8:0]  nxt;
    logic [8:0]  par;
    logic [9:0]  idx;
    sym_res_t    r;
    case (it.act)
      ACT_CLEAR: begin
        open_sp  = 0;
        node_cnt = '0;
        prev_int = 1'b0;
        walk_pos = '0;
      end
      ACT_LOAD: begin
        idx = node_cnt;
        // full table, complete tree and full stack all drop the load
        if (idx < NodeCap && !(idx > 0 && !prev_int && open_sp == 0) &&
            !(it.internal && open_sp >= MaxSym)) begin
          if (idx > 0) begin
            if (prev_int) begin
              code_tree[idx - 1][17:9] = idx[8:0];
            end else begin
              open_sp--;
              par = open_parents[open_sp];
              code_tree[par][8:0] = idx[8:0];
            end
          end
          if (it.internal) begin
            code_tree[idx] = '0;
            open_parents[open_sp] = idx[8:0];
            open_sp++;
            prev_int = 1'b1;
          end else begin
            code_tree[idx] = {1'b1, it.sym, 18'd0};
            prev_int = 1'b0;
          end
          node_cnt = idx + 10'd1;
        end
      end
      ACT_DECODE: begin
        ent = node_at(walk_pos);
        if (ent[26]) begin
          r = '{sym: ent[25:18], incomplete: 1'b0, last: it.fin};
          sym_exp_q.push_back(r);
          walk_pos = '0;
        end else begin
          nxt = it.cbit ? ent[8:0] : ent[17:9];
          ent = node_at(nxt);
          if (ent[26]) begin
            r = '{sym: ent[25:18], incomplete: 1'b0, last: it.fin};
            sym_exp_q.push_back(r);
            walk_pos = '0;
          end else if (it.fin) begin
            r = '{sym: '0, incomplete: 1'b1, last: 1'b1};
            sym_exp_q.push_back(r);
            walk_pos = '0;
          end else begin
            walk_pos = nxt;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic queue_item(input act_e a, input logic n, input logic [SymW-1:0] s,
                            input logic c, input logic f);
    stim_t st;
    st.act      = a;
    st.internal = n;
    st.sym      = s;
    st.cbit     = c;
    st.fin      = f;
    st.drain    = 1'b0;
    st.hold     = 1'b0;
    stim_q.push_back(st);
  endtask

  task automatic queue_clear();
    queue_item(ACT_CLEAR, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic queue_load(input logic n);
    logic [SymW-1:0] s;
    s = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 7) == 0) s = $urandom_range(0, 1) ? 8'hff : 8'h00;
    queue_item(ACT_LOAD, n, s, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // random full binary tree in pre-order, recording each leaf's code
  task automatic queue_tree(input int leaves);
    int          ints_left;
    int          free_slots;
    logic [63:0] pb;
    int          pl;
    logic [63:0] right_bits [$];
    int          right_len [$];
    ints_left  = leaves - 1;
    free_slots = 1;
    pb         = '0;
    pl         = 0;
    leaf_bits.delete();
    leaf_len.delete();
    while (free_slots > 0) begin
      if (ints_left > 0 && (free_slots == 1 || $urandom_range(0, 1) == 1)) begin
        queue_load(1'b1);
        ints_left--;
        free_slots++;
        right_bits.push_back(pb | (64'd1 << pl));
        right_len.push_back(pl + 1);
        pl++;
      end else begin
        queue_load(1'b0);
        leaf_bits.push_back(pb);
        leaf_len.push_back(pl);
        free_slots--;
        if (free_slots > 0) begin
          pb = right_bits.pop_back();
          pl = right_len.pop_back();
        end
      end
    end
  endtask

  task automatic queue_stream(input int words, input bit partial, input bit with_final);
    logic cbits [$];
    int   k;
    int   n;
    for (int w = 0; w < words; w++) begin
      k = $urandom_range(0, leaf_len.size() - 1);
      if (leaf_len[k] == 0) cbits.push_back(1'($urandom_range(0, 1)));
      else for (int j = 0; j < leaf_len[k]; j++) cbits.push_back(leaf_bits[k][j]);
    end
    if (partial) begin
      k = $urandom_range(0, leaf_len.size() - 1);
      if (leaf_len[k] >= 2) begin
        n = $urandom_range(1, leaf_len[k] - 1);
        for (int j = 0; j < n; j++) cbits.push_back(leaf_bits[k][j]);
      end
    end
    foreach (cbits[i])
      queue_item(ACT_DECODE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                 cbits[i], with_final && (i == cbits.size() - 1));
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_busy = 1'b0;
      src_gap  = 0;
      cur_stim = '0;
      in_if.valid            <= 1'b0;
      in_if.action           <= ACT_NOP;
      in_if.node_is_internal <= 1'b0;
      in_if.leaf_symbol      <= '0;
      in_if.code_bit         <= 1'b0;
      in_if.final_bit        <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        walk_tree_item(cur_stim);
        src_busy = 1'b0;
      end
      if (src_gap > 0) begin
        src_gap--;
      end else if (!src_busy && stim_q.size() > 0) begin
        if (idling_allowed() && $urandom_range(0, 3) == 0) begin
          src_gap = $urandom_range(1, 13) - 1;
        end else if (!stim_q[0].drain || sym_exp_q.size() == 0) begin
          cur_stim = stim_q.pop_front();
          src_busy = 1'b1;
          if (cur_stim.hold) hold_tick <= hold_tick + 1;
        end
      end
      in_if.valid            <= src_busy;
      in_if.action           <= cur_stim.act;
      in_if.node_is_internal <= cur_stim.internal;
      in_if.leaf_symbol      <= cur_stim.sym;
      in_if.code_bit         <= cur_stim.cbit;
      in_if.final_bit        <= cur_stim.fin;
    end
  end

  // monitor and receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (sym_exp_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected item: symbol %0h incomplete %0b last %0b",
                     out_if.symbol, out_if.incomplete, out_if.last);
        end else begin
          sym_res_t e;
          e = sym_exp_q.pop_front();
          if (out_if.symbol !== e.sym || out_if.incomplete !== e.incomplete ||
              out_if.last !== e.last) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch: symbol exp %0h got %0h, incomplete exp %0b got %0b, %s",
                       e.sym, out_if.symbol, e.incomplete, out_if.incomplete,
                       $sformatf("last exp %0b got %0b", e.last, out_if.last));
          end
        end
      end
      if (hold_tick != hold_seen) begin
        hold_seen = hold_tick;
        hold_cnt  = HoldCyc;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        snk_rdy = 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        snk_rdy = 1'b0;
      end else if (idling_allowed() && $urandom_range(0, 3) == 0) begin
        snk_gap = $urandom_range(1, 13) - 1;
        snk_rdy = 1'b0;
      end else begin
        snk_rdy = 1'b1;
      end
      out_if.ready <= snk_rdy;
    end
  end

  initial begin
    #(12 * 400000);
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_ni                 = 1'b0;
    in_if.valid            = 1'b0;
    in_if.action           = ACT_NOP;
    in_if.node_is_internal = 1'b0;
    in_if.leaf_symbol      = '0;
    in_if.code_bit         = 1'b0;
    in_if.final_bit        = 1'b0;
    out_if.ready           = 1'b0;

    foreach (code_tree[i]) code_tree[i] = '0;
    foreach (open_parents[i]) open_parents[i] = '0;
    open_sp  = 0;
    node_cnt = '0;
    prev_int = 1'b0;
    walk_pos = '0;

    // root is a leaf: every bit emits it
    queue_item(ACT_LOAD, 1'b0, 8'hff, 1'b0, 1'b0);
    queue_item(ACT_DECODE, 1'b0, 8'h00, 1'b0, 1'b0);
    queue_item(ACT_DECODE, 1'b1, 8'hff, 1'b1, 1'b1);
    // three-leaf tree, then loads after the tree is complete
    queue_item(ACT_CLEAR, 1'b1, 8'hff, 1'b1, 1'b1);
    queue_item(ACT_LOAD, 1'b1, 8'h00, 1'b0, 1'b0);
    queue_item(ACT_LOAD, 1'b0, 8'h00, 1'b1, 1'b1);
    queue_item(ACT_LOAD, 1'b1, 8'hff, 1'b0, 1'b0);
    queue_item(ACT_LOAD, 1'b0, 8'ha5, 1'b0, 1'b0);
    queue_item(ACT_LOAD, 1'b0, 8'h5a, 1'b0, 1'b0);
    queue_item(ACT_LOAD, 1'b0, 8'h11, 1'b0, 1'b0);
    queue_item(ACT_LOAD, 1'b1, 8'h22, 1'b0, 1'b0);
    queue_item(ACT_DECODE, 1'b0, 8'h00, 1'b0, 1'b0);
    queue_item(ACT_DECODE, 1'b1, 8'hff, 1'b1, 1'b0);
    queue_item(ACT_DECODE, 1'b0, 8'h00, 1'b0, 1'b0);
    queue_item(ACT_DECODE, 1'b0, 8'h00, 1'b1, 1'b0);
    queue_item(ACT_DECODE, 1'b0, 8'h00, 1'b1, 1'b1);
    // stream ends mid-code
    queue_item(ACT_DECODE, 1'b0, 8'h00, 1'b1, 1'b1);
    queue_item(ACT_NOP, 1'b1, 8'h96, 1'b1, 1'b1);
    // unfinished tree: unset links lead back to the root
    queue_item(ACT_CLEAR, 1'b0, 8'h00, 1'b0, 1'b0);
    queue_item(ACT_LOAD, 1'b1, 8'h00, 1'b0, 1'b0);
    queue_item(ACT_LOAD, 1'b1, 8'h00, 1'b0, 1'b0);
    queue_item(ACT_DECODE, 1'b0, 8'h00, 1'b1, 1'b0);
    queue_item(ACT_DECODE, 1'b0, 8'h00, 1'b0, 1'b1);

    rnd_cnt = stim_q.size();
    seg     = 0;
    while (stim_q.size() - rnd_cnt < RandItems) begin
      pick = $urandom_range(0, 99);
      if (seg == 0) begin
        // largest tree, then loads past capacity
        queue_clear();
        queue_tree(MaxSym);
        queue_load(1'b0);
        queue_load(1'b1);
        queue_load(1'b0);
        queue_stream(4, 1'b0, 1'b1);
      end else if (seg == 1) begin
        // internal chain until the parent stack is full
        queue_clear();
        for (int i = 0; i < MaxSym + 2; i++) queue_load(1'b1);
        for (int i = 0; i < 5; i++) queue_load(1'b0);
        for (int i = 0; i < 10; i++)
          queue_item(ACT_DECODE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), i == 9);
      end else if (seg == 2) begin
        // sender waits for all results, then the receiver holds off
        queue_clear();
        stim_q[stim_q.size() - 1].drain = 1'b1;
        queue_tree(1);
        queue_stream(40, 1'b0, 1'b1);
        stim_q[stim_q.size() - 40].hold = 1'b1;
      end else if (pick < 65) begin
        queue_clear();
        nleaf = $urandom_range(2, 8);
        if (pick < 4) nleaf = 1;
        else if (pick < 14) nleaf = $urandom_range(9, MaxSym);
        queue_tree(nleaf);
        queue_stream($urandom_range(1, 8), $urandom_range(0, 3) == 0,
                     $urandom_range(0, 4) != 0);
      end else if (pick < 80) begin
        queue_stream($urandom_range(1, 4), $urandom_range(0, 1) == 1,
                     $urandom_range(0, 1) == 1);
      end else begin
        for (int i = $urandom_range(3, 15); i > 0; i--)
          queue_item(act_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
      end
      seg++;
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() != 0 || src_busy) @(posedge clk_i);
    while (sym_exp_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (err_cnt == 0 && sym_exp_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
